[sv/lru_key_value_cache_unit_assert.svh]
// assertion macros for the lru key/value cache unit
// expects clk and arst_n in the scope of each use
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// condition must hold at every edge outside reset
`define LKVC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/lkvc_pkg.sv]
// shared types and constants for the lru key/value cache unit
// no dependencies
package lkvc_pkg;

	localparam int DEPTH   = 16;
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;
	localparam int CFG_W   = 5;
	localparam int AGE_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_INSERT = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_MISS      = 3'd0,
		ST_HIT       = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_EVICTED   = 3'd3,
		ST_DUPLICATE = 3'd4
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] hit_value;
		logic [KEY_W-1:0]   evicted_key;
		logic [VALUE_W-1:0] evicted_value;
	} rsp_t;

endpackage

[sv/lru_key_value_cache_unit.sv]
// top level of the lru key/value cache unit: fully associative store with lru eviction
// depends on lkvc_pkg and lru_key_value_cache_unit_assert.svh
`include "lru_key_value_cache_unit_assert.svh"

// Fully associative key/value cache of DEPTH entries with least-recently-used
// replacement. Each request transaction (lookup or insert) produces exactly one
// response transaction. Throughput is one transaction per cycle while rsp_ready is
// high: the request is captured in an input register, all DEPTH keys are compared
// in parallel and the per-entry ages are updated in a single combinational pass,
// and the response is captured in an output register. The output register
// decouples the two sides, so one new request can be taken into the input
// register while a finished response waits for rsp_ready. The store is
// empty after reset and after every write of the limit register; there is no
// clearing pass, entries are tracked by per-entry valid bits. Write cfg_we only
// while no transaction is in flight. A limit of zero acts as one, and a limit
// above DEPTH acts as DEPTH.
module lru_key_value_cache_unit
	import lkvc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	// response channel
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	// limit register write port
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	// input stage
	req_t req_s1;
	logic req_valid_s1;

	// output stage
	rsp_t rsp_s2;
	logic rsp_valid_s2;

	// entry store
	logic [DEPTH-1:0]   valid_q;
	logic [KEY_W-1:0]   key_q   [DEPTH];
	logic [VALUE_W-1:0] value_q [DEPTH];
	logic [AGE_W-1:0]   age_q   [DEPTH];
	logic [AGE_W-1:0]   age_d   [DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   limit_d;

	// single-pass datapath
	logic               advance;
	logic               is_insert;
	logic               full;
	logic               hit_any;
	logic               do_write;
	logic               do_touch;
	logic [DEPTH-1:0]   hit_vec;
	logic [DEPTH-1:0]   victim_vec;
	logic [DEPTH-1:0]   free_vec;
	logic [DEPTH-1:0]   wr_vec;
	logic [DEPTH-1:0]   rd_vec;
	logic [AGE_W-1:0]   hit_age;
	logic [VALUE_W-1:0] rd_value;
	logic [KEY_W-1:0]   victim_key;
	rsp_t               rsp_d;

	// the s1 transaction is processed when the output register is free or draining
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	assign is_insert = (req_s1.cmd == CMD_INSERT);
	assign full      = (count_q >= limit_q);

	// parallel key match, victim (oldest) search and lowest free slot
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit_vec[i]    = valid_q[i] && (key_q[i] == req_s1.key);
			victim_vec[i] = valid_q[i] && ((CNT_W'(age_q[i]) + CNT_W'(1)) == count_q);
		end
	end

	// isolate the lowest clear valid bit
	assign free_vec = ~valid_q & (valid_q + DEPTH'(1));
	assign hit_any  = |hit_vec;

	// one read select serves both the hit value and the evicted value
	assign rd_vec = is_insert ? victim_vec : hit_vec;

	always_comb begin
		hit_age    = '0;
		rd_value   = '0;
		victim_key = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit_vec[i]) begin
				hit_age = hit_age | age_q[i];
			end
			if (rd_vec[i]) begin
				rd_value = rd_value | value_q[i];
			end
			if (victim_vec[i]) begin
				victim_key = victim_key | key_q[i];
			end
		end
	end

	// insert of a new key writes the victim slot when full, else the free slot
	assign do_write = advance && is_insert && !hit_any;
	assign do_touch = advance && !is_insert && hit_any;
	assign wr_vec   = full ? victim_vec : free_vec;

	// age update: a hit ages the younger entries, an insert of a new key ages every other valid one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			age_d[i] = age_q[i];
			if (do_touch) begin
				if (hit_vec[i]) begin
					age_d[i] = '0;
				end else if (valid_q[i] && (age_q[i] < hit_age)) begin
					age_d[i] = age_q[i] + AGE_W'(1);
				end
			end else if (do_write) begin
				if (wr_vec[i]) begin
					age_d[i] = '0;
				end else if (valid_q[i]) begin
					age_d[i] = age_q[i] + AGE_W'(1);
				end
			end
		end
	end

	// response of the s1 transaction
	always_comb begin
		rsp_d = '0;
		if (!is_insert) begin
			if (hit_any) begin
				rsp_d.status    = ST_HIT;
				rsp_d.hit_value = rd_value;
			end else begin
				rsp_d.status = ST_MISS;
			end
		end else if (hit_any) begin
			rsp_d.status = ST_DUPLICATE;
		end else if (full) begin
			rsp_d.status        = ST_EVICTED;
			rsp_d.evicted_key   = victim_key;
			rsp_d.evicted_value = rd_value;
		end else begin
			rsp_d.status = ST_INSERTED;
		end
	end

	// limit clamp: zero acts as one, values above DEPTH act as DEPTH
	always_comb begin
		if (cfg_wdata == '0) begin
			limit_d = CNT_W'(1);
		end else if (int'(cfg_wdata) > DEPTH) begin
			limit_d = CNT_W'(DEPTH);
		end else begin
			limit_d = CNT_W'(cfg_wdata);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	// control state of the store; a limit write empties it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			limit_q <= CNT_W'(DEPTH);
			for (int i = 0; i < DEPTH; i++) begin
				age_q[i] <= '0;
			end
		end else if (cfg_we) begin
			valid_q <= '0;
			count_q <= '0;
			limit_q <= limit_d;
			for (int i = 0; i < DEPTH; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < DEPTH; i++) begin
				age_q[i] <= age_d[i];
			end
			if (do_write) begin
				valid_q <= valid_q | wr_vec;
				if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// key and value storage, written at the selected slot only
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (do_write && wr_vec[i]) begin
				key_q[i]   <= req_s1.key;
				value_q[i] <= req_s1.value;
			end
		end
	end

	`LKVC_ASSERT_ALWAYS(a_count_matches_valid, ($countones(valid_q) == int'(count_q)),
		"entry count differs from number of valid entries")
	`LKVC_ASSERT_ALWAYS(a_count_within_limit, (count_q <= limit_q),
		"entry count exceeds the configured limit")
	`LKVC_ASSERT_ALWAYS(a_unique_keys, ($onehot0(hit_vec)),
		"key matches more than one valid entry")
	`LKVC_ASSERT_SAME(a_victim_found, (do_write && full), ($onehot(victim_vec)),
		"no unique oldest entry on an evicting insert")
	`LKVC_ASSERT_NEXT(a_insert_grows, (do_write && !full && !cfg_we),
		(count_q == $past(count_q) + CNT_W'(1)),
		"insert into a non-full store did not grow the count")

endmodule
